### sv/abuf_pkg.sv
// Shared types and constants for the bounded append buffer with number-to-ASCII conversion.
// Holds the request and result payload structs, the operation and status codes, and the
// sequencer states. No dependencies.
package abuf_pkg;

    // Buffer and conversion limits
    localparam int unsigned MAX_BYTES_DEF = 4096;
    localparam int unsigned MAX_DIGITS    = 10;
    localparam int unsigned DIG_IDX_W     = $clog2(MAX_DIGITS);
    localparam int unsigned DIG_CNT_W     = $clog2(MAX_DIGITS + 1);

    // Field widths
    localparam int unsigned CAP_W  = 13;
    localparam int unsigned ADDR_W = 12;

    // Operation codes
    localparam logic [1:0] OP_APPEND_BYTE = 2'd0;
    localparam logic [1:0] OP_APPEND_NUM  = 2'd1;
    localparam logic [1:0] OP_CLEAR       = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_INVALID = 2'd2;

    // Accepted number bases
    localparam logic [7:0] RADIX_DEC = 8'd10;
    localparam logic [7:0] RADIX_HEX = 8'd16;

    // Digit encoding
    localparam logic [3:0]  DIGIT_TEN = 4'hA;
    localparam logic [7:0]  CHAR_ZERO = 8'h30;
    localparam logic [7:0]  CHAR_UPPER_A = 8'h41;

    // ceil(2^35 / 10): floor(v * RECIP10 / 2^35) == v / 10 for all 32-bit v
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  byte_value;
        logic [31:0] number_value;
        logic [7:0]  radix;
    } abuf_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              wrote;
        logic [ADDR_W-1:0] write_addr;
        logic [7:0]        write_char;
        logic [CAP_W-1:0]  fill_level;
        logic              last;
    } abuf_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_CONV,
        ST_CHECK,
        ST_EMIT
    } abuf_state_t;

endpackage

### sv/bounded_append_buffer_with_utoa.sv
// Top level of the bounded append buffer: fill count, capacity register, digit sequencer.
// Depends on abuf_pkg for payload structs, codes and sequencer states.
//
// One request is taken at a time. A clear, a byte append, or a request rejected for its base
// or its op gives a single result. A number append runs the value through one shared
// divide-by-radix unit (a reciprocal multiply for base 10, a 4-bit shift for base 16), one
// digit per cycle, then checks the free space and sends the digits out one per cycle while
// the result side does not stall, most significant first. A number that does not fit is
// rejected after the sizing pass and the space check. The result register lets a finished
// result wait while the block goes back to taking requests.
module bounded_append_buffer_with_utoa #(
    parameter int unsigned MAX_BYTES = abuf_pkg::MAX_BYTES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [abuf_pkg::CAP_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  abuf_pkg::abuf_req_t       in_req,
    output logic                      out_valid,
    input  logic                      out_stall,
    output abuf_pkg::abuf_res_t       out_res
);
    import abuf_pkg::*;

    abuf_state_t state_reg, state_next;
    logic [CAP_W-1:0]     cap_reg, cap_next;
    logic [CAP_W-1:0]     fill_reg, fill_next;
    logic [DIG_CNT_W-1:0] n_reg, n_next;
    logic [DIG_IDX_W-1:0] idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    abuf_res_t            out_res_reg, out_res_next;
    abuf_req_t            req_reg, req_next;
    logic [31:0]          v_reg, v_next;
    logic [7:0]           dig_mem [MAX_DIGITS];

    logic [CAP_W-1:0] eff_cap;
    logic [CAP_W-1:0] free_bytes;
    logic             slot_free;
    logic             load;
    abuf_res_t        res_d;
    logic             radix_ok_in;
    logic             radix_ok_reg;
    logic             hex_mode;
    logic [63:0]      prod;
    logic [31:0]      quot;
    logic [31:0]      q10;
    logic [31:0]      rem10;
    logic [3:0]       digit;
    logic [7:0]       digit_char;

    // Saturate the capacity and derive the free space
    always_comb
    begin
        if ({4'b0, cap_reg} > 17'(MAX_BYTES))
            eff_cap = CAP_W'(MAX_BYTES);
        else
            eff_cap = cap_reg;
        free_bytes = (eff_cap > fill_reg) ? (eff_cap - fill_reg) : '0;
    end

    assign radix_ok_in  = (in_req.radix == RADIX_DEC) || (in_req.radix == RADIX_HEX);
    assign radix_ok_reg = (req_reg.radix == RADIX_DEC) || (req_reg.radix == RADIX_HEX);
    assign hex_mode     = (req_reg.radix == RADIX_HEX);

    // Shared divide-by-radix unit: one quotient and one digit per cycle
    assign prod  = v_reg * RECIP10;
    assign q10   = {3'b0, prod[63:35]};
    assign rem10 = v_reg - ((q10 << 3) + (q10 << 1));

    always_comb
    begin
        if (hex_mode)
        begin
            quot  = v_reg >> 4;
            digit = v_reg[3:0];
        end
        else
        begin
            quot  = q10;
            digit = rem10[3:0];
        end
        if (digit < DIGIT_TEN)
            digit_char = CHAR_ZERO + {4'b0, digit};
        else
            digit_char = CHAR_UPPER_A + {4'b0, digit - DIGIT_TEN};
    end

    assign slot_free = !out_valid_reg || !out_stall;

    // Sequencer: next state, counters and result build
    always_comb
    begin
        state_next = state_reg;
        cap_next   = cfg_write ? cfg_data : cap_reg;
        fill_next  = fill_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        req_next   = req_reg;
        v_next     = v_reg;
        in_stall   = (state_reg != ST_IDLE);
        load       = 1'b0;
        res_d      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next = in_req;
                    v_next   = in_req.number_value;
                    n_next   = '0;
                    if (in_req.op == OP_APPEND_NUM && radix_ok_in)
                        state_next = ST_CONV;
                    else
                        state_next = ST_SINGLE;
                end
            end
            ST_SINGLE:
            begin
                if (slot_free)
                begin
                    load             = 1'b1;
                    res_d.last       = 1'b1;
                    res_d.fill_level = fill_reg;
                    case (req_reg.op)
                        OP_CLEAR:
                        begin
                            fill_next        = '0;
                            res_d.fill_level = '0;
                            res_d.status     = STAT_OK;
                        end
                        OP_APPEND_BYTE:
                        begin
                            if (free_bytes == '0)
                                res_d.status = STAT_FULL;
                            else
                            begin
                                res_d.status     = STAT_OK;
                                res_d.wrote      = 1'b1;
                                res_d.write_addr = fill_reg[ADDR_W-1:0];
                                res_d.write_char = req_reg.byte_value;
                                fill_next        = fill_reg + 1'b1;
                                res_d.fill_level = fill_reg + 1'b1;
                            end
                        end
                        // a number lands here only when rejected
                        OP_APPEND_NUM:
                            res_d.status = radix_ok_reg ? STAT_FULL : STAT_INVALID;
                        default:
                            res_d.status = STAT_INVALID;
                    endcase
                    state_next = ST_IDLE;
                end
            end
            ST_CONV:
            begin
                v_next = quot;
                n_next = n_reg + 1'b1;
                if (quot == '0 || n_reg == DIG_CNT_W'(MAX_DIGITS - 1))
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // all-or-nothing: reject when the digits do not fit
                if (CAP_W'(n_reg) > free_bytes)
                    state_next = ST_SINGLE;
                else
                begin
                    idx_next   = DIG_IDX_W'(n_reg - 1'b1);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    load             = 1'b1;
                    res_d.status     = STAT_OK;
                    res_d.wrote      = 1'b1;
                    res_d.write_addr = fill_reg[ADDR_W-1:0];
                    res_d.write_char = dig_mem[idx_reg];
                    res_d.fill_level = fill_reg + 1'b1;
                    res_d.last       = (idx_reg == '0);
                    fill_next        = fill_reg + 1'b1;
                    if (idx_reg == '0)
                        state_next = ST_IDLE;
                    else
                        idx_next = idx_reg - 1'b1;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        out_valid_next = load || (out_valid_reg && out_stall);
        out_res_next   = load ? res_d : out_res_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_W'(MAX_BYTES_DEF);
            fill_reg      <= '0;
            n_reg         <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            fill_reg      <= fill_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers and digit store, least significant digit at entry zero
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        v_reg       <= v_next;
        out_res_reg <= out_res_next;
        if (state_reg == ST_CONV)
            dig_mem[DIG_IDX_W'(n_reg)] <= digit_char;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

### sv/abuf_checker.sv
// Port-level checks for the bounded append buffer, attached to the top level by bind.
// Depends on abuf_pkg for the payload structs and status codes.
module abuf_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input abuf_pkg::abuf_res_t        out_res
);
    import abuf_pkg::*;

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_res))
        else $error("stalled result changed");

    // Stall the next request right after one is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while busy");

    // Stall requests while a non-final digit of a number waits at the output
    a_busy_mid_number: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_res.last |-> in_stall)
        else $error("request taken before last result");

    // A written character always carries status ok
    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_res.wrote |-> out_res.status == STAT_OK)
        else $error("write with error status");

    // The fill level advances past the written position
    a_fill_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_res.wrote |->
            out_res.write_addr == out_res.fill_level[ADDR_W-1:0] - 12'd1)
        else $error("fill level does not follow write address");

endmodule

bind bounded_append_buffer_with_utoa abuf_checker u_abuf_checker (.*);
